// ===== design/tsts_pkg.sv =====
// ----------------------------------------------------------------------------
// tsts_pkg
// Shared types and codes for the timer slot table scheduler.
// ----------------------------------------------------------------------------
package tsts_pkg;

  // input selector codes
  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CANCEL = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_ADD_REPLY    = 3'd0;
  localparam logic [2:0] KIND_ACTION       = 3'd1;
  localparam logic [2:0] KIND_CALLBACK     = 3'd2;
  localparam logic [2:0] KIND_CANCEL_REPLY = 3'd3;
  localparam logic [2:0] KIND_TICK_DONE    = 3'd4;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] period_ms;
    logic [15:0] repeat_count;
    logic        has_action;
    logic [7:0]  action_id;
    logic        has_alternate;
    logic [7:0]  alternate_id;
    logic        has_callback;
    logic [7:0]  callback_id;
    logic [7:0]  slot_index;
    logic [31:0] now_ms;
  } tsts_in_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] slot;
    logic [7:0] event_id;
    logic       accepted;
    logic [7:0] active_count;
    logic       last;
  } tsts_out_t;

  // optional event id with its valid flag
  typedef struct packed {
    logic       vld;
    logic [7:0] id;
  } tsts_ev_t;

  // one slot record as held in the slot RAM
  typedef struct packed {
    logic [15:0] period;
    logic [31:0] trigger;
    logic [15:0] repeats;
    tsts_ev_t    main_ev;
    tsts_ev_t    alt_ev;
    tsts_ev_t    done_ev;
  } tsts_slot_t;

endpackage

// ===== design/timer_slot_table_scheduler.sv =====
// ----------------------------------------------------------------------------
// timer_slot_table_scheduler
// Table of software timer slots: add, cancel and a per-millisecond tick scan.
// ----------------------------------------------------------------------------
// One word is handled at a time; in_stall stays high from acceptance until
// the last result word of that input has been loaded into the output
// register. A cancel is settled in its own single state. An add steps past the
// occupied slots in index order to the first free one. A tick walks every
// slot in index order: a free slot is only checked, an occupied slot is
// also read from the slot RAM and compared, and a due slot is then updated
// as well, before the closing tick done word. The pace is set by the slot
// RAM, read one slot at a time, and by the one 32-bit adder that does both
// the due compare and the rearm sum. Every step waits while the output
// register is held by out_stall, so a slow consumer slows each of these
// steps.
// ----------------------------------------------------------------------------
module timer_slot_table_scheduler
  import tsts_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  tsts_in_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output tsts_out_t out_word
);

  localparam int         SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [7:0] SLOTS_C = 8'(SLOTS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
  localparam int         REC_W   = $bits(tsts_slot_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_CANCEL,
    S_TICK_RD,
    S_TICK_EVAL,
    S_TICK_UPD,
    S_TICK_DONE
  } state_t;

  state_t      state_r, state_nxt;
  tsts_in_t    cmd_r, cmd_nxt;
  logic [SLOT_W-1:0] ptr_r, ptr_nxt;
  logic [SLOTS-1:0]  busy_r, busy_nxt;
  logic [7:0]  count_r, count_nxt;
  logic        out_valid_r, out_valid_nxt;
  tsts_out_t   out_word_r, out_word_nxt;

  // slot RAM
  logic        ram_we, ram_re;
  tsts_slot_t  wr_rec, rd_rec;
  logic [REC_W-1:0] ram_rdata;

  // shared adder: compare (now - trigger) or sum (now + period)
  logic        use_cmp;
  logic [31:0] add_b;
  logic [32:0] add_sum;
  logic        due;

  // control
  logic        accept, go, ptr_last, cancel_hit;

  assign accept   = in_valid && !in_stall;
  assign go       = !out_valid_r || !out_stall;
  assign ptr_last = (ptr_r == LAST_SLOT);
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign rd_rec = tsts_slot_t'(ram_rdata);

  assign use_cmp = (state_r == S_TICK_EVAL);
  always_comb begin
    if (use_cmp) begin
      add_b = ~rd_rec.trigger;
    end else if (state_r == S_ADD) begin
      add_b = {16'd0, cmd_r.period_ms};
    end else begin
      add_b = {16'd0, rd_rec.period};
    end
  end
  assign add_sum = {1'b0, cmd_r.now_ms} + {1'b0, add_b} + {32'd0, use_cmp};
  // carry out of now + ~trigger + 1 means now >= trigger
  assign due = add_sum[32];

  assign cancel_hit = (cmd_r.slot_index < SLOTS_C) &&
                      busy_r[cmd_r.slot_index[SLOT_W-1:0]];

  tsts_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ptr_r),
    .wr_data (wr_rec),
    .rd_en   (ram_re),
    .rd_addr (ptr_r),
    .rd_data (ram_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    ptr_nxt       = ptr_r;
    busy_nxt      = busy_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    wr_rec        = rd_rec;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_word;
          ptr_nxt = '0;
          case (in_word.action)
            ACT_ADD:    state_nxt = S_ADD;
            ACT_CANCEL: state_nxt = S_CANCEL;
            ACT_TICK:   state_nxt = S_TICK_RD;
            default:    state_nxt = S_IDLE;  // unused selector: dropped
          endcase
        end
      end

      S_ADD: begin
        if (go) begin
          if (count_r >= SLOTS_C || (busy_r[ptr_r] && ptr_last)) begin
            // table full: refusal carries the count
            out_valid_nxt = 1'b1;
            out_word_nxt  = '{kind: KIND_ADD_REPLY, slot: count_r, event_id: 8'd0,
                              accepted: 1'b0, active_count: count_r, last: 1'b1};
            state_nxt     = S_IDLE;
          end else if (!busy_r[ptr_r]) begin
            ram_we          = 1'b1;
            wr_rec.period   = cmd_r.period_ms;
            wr_rec.trigger  = add_sum[31:0];
            wr_rec.repeats  = cmd_r.repeat_count;
            wr_rec.main_ev  = '{vld: cmd_r.has_action,    id: cmd_r.action_id};
            wr_rec.alt_ev   = '{vld: cmd_r.has_alternate, id: cmd_r.alternate_id};
            wr_rec.done_ev  = '{vld: cmd_r.has_callback,  id: cmd_r.callback_id};
            busy_nxt[ptr_r] = 1'b1;
            count_nxt       = count_r + 8'd1;
            out_valid_nxt   = 1'b1;
            out_word_nxt    = '{kind: KIND_ADD_REPLY, slot: 8'(ptr_r), event_id: 8'd0,
                                accepted: 1'b1, active_count: count_r + 8'd1,
                                last: 1'b1};
            state_nxt       = S_IDLE;
          end else begin
            ptr_nxt = ptr_r + SLOT_W'(1);
          end
        end
      end

      S_CANCEL: begin
        if (go) begin
          if (cancel_hit) begin
            busy_nxt[cmd_r.slot_index[SLOT_W-1:0]] = 1'b0;
            count_nxt = count_r - 8'd1;
          end
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{kind: KIND_CANCEL_REPLY, slot: cmd_r.slot_index,
                            event_id: 8'd0, accepted: cancel_hit,
                            active_count: cancel_hit ? count_r - 8'd1 : count_r,
                            last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      S_TICK_RD: begin
        if (go) begin
          if (busy_r[ptr_r]) begin
            ram_re    = 1'b1;
            state_nxt = S_TICK_EVAL;
          end else if (ptr_last) begin
            state_nxt = S_TICK_DONE;
          end else begin
            ptr_nxt = ptr_r + SLOT_W'(1);
          end
        end
      end

      S_TICK_EVAL: begin
        if (go) begin
          if (due) begin
            if (rd_rec.main_ev.vld) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{kind: KIND_ACTION, slot: 8'(ptr_r),
                                event_id: rd_rec.main_ev.id, accepted: 1'b0,
                                active_count: count_r, last: 1'b0};
            end
            state_nxt = S_TICK_UPD;
          end else if (ptr_last) begin
            state_nxt = S_TICK_DONE;
          end else begin
            ptr_nxt   = ptr_r + SLOT_W'(1);
            state_nxt = S_TICK_RD;
          end
        end
      end

      S_TICK_UPD: begin
        if (go) begin
          if (rd_rec.repeats == 16'd1) begin
            // last firing: free the slot, then the callback if any
            busy_nxt[ptr_r] = 1'b0;
            count_nxt       = count_r - 8'd1;
            if (rd_rec.done_ev.vld) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{kind: KIND_CALLBACK, slot: 8'(ptr_r),
                                event_id: rd_rec.done_ev.id, accepted: 1'b0,
                                active_count: count_r - 8'd1, last: 1'b0};
            end
          end else begin
            ram_we         = 1'b1;
            wr_rec.trigger = add_sum[31:0];
            if (rd_rec.alt_ev.vld) begin
              wr_rec.main_ev = rd_rec.alt_ev;
              wr_rec.alt_ev  = rd_rec.main_ev;
            end
            if (rd_rec.repeats > 16'd1) begin
              wr_rec.repeats = rd_rec.repeats - 16'd1;
            end
          end
          if (ptr_last) begin
            state_nxt = S_TICK_DONE;
          end else begin
            ptr_nxt   = ptr_r + SLOT_W'(1);
            state_nxt = S_TICK_RD;
          end
        end
      end

      S_TICK_DONE: begin
        if (go) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = '{kind: KIND_TICK_DONE, slot: 8'd0, event_id: 8'd0,
                            accepted: 1'b0, active_count: count_r, last: 1'b1};
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      busy_r      <= '0;
      count_r     <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      busy_r      <= busy_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
  end

endmodule

// ===== design/tsts_ram.sv =====
// ----------------------------------------------------------------------------
// tsts_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sim/timer_slot_table_scheduler_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// timer_slot_table_scheduler_test
// Self-checking bench for the timer slot table. A scoreboard object keeps its
// own copy of the slot table and, for every accepted input word, queues the
// reply, event and tick done words that the table should produce. Each result
// word is matched field by field against the oldest queued one. Stimulus is a
// short directed run, then random add/cancel/tick traffic under three idling
// mixes, with one long output hold-off to back the block up.
// ----------------------------------------------------------------------------
module timer_slot_table_scheduler_test;
  import tsts_pkg::*;

  localparam int SLOTS          = 8;
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no word accepted
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 40;    // settle time after the last result
  localparam int PHASE_ITEMS    = 75;    // three random phases, 225 counted words
  localparam int MAX_REPORTS    = 40;    // cap on mismatch lines

  // selector code the block has no use for; such words are dropped
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow slot table plus the queue of awaited result words
  // --------------------------------------------------------------------------
  class slot_table_scoreboard;
    bit             busy   [SLOTS];
    logic [15:0]    period [SLOTS];
    logic [31:0]    trigger[SLOTS];
    logic [15:0]    reps   [SLOTS];
    tsts_ev_t       main_ev[SLOTS];
    tsts_ev_t       alt_ev [SLOTS];
    tsts_ev_t       done_ev[SLOTS];
    logic [7:0]     live_count;
    tsts_out_t      awaited_q[$];
    int             fail_count;

    function new();
      foreach (busy[i]) busy[i] = 1'b0;
      live_count = '0;
      fail_count = 0;
    endfunction

    function int pending();
      return awaited_q.size();
    endfunction

    // active_count is taken from the table as it stands at this point
    function void queue_reply(logic [2:0] kind, logic [7:0] slot, logic [7:0] id,
                              logic acc);
      tsts_out_t t;
      t.kind         = kind;
      t.slot         = slot;
      t.event_id     = id;
      t.accepted     = acc;
      t.active_count = live_count;
      t.last         = 1'b0;
      awaited_q.push_back(t);
    endfunction

    // Update the shadow table for one accepted command word
    function void apply_command(tsts_in_t w);
      int        n0;
      bit        took;
      bit        freed;
      tsts_ev_t  swap;
      tsts_out_t t;
      n0 = awaited_q.size();
      case (w.action)
        ACT_ADD: begin
          took = 1'b0;
          if (live_count < SLOTS) begin
            for (int i = 0; i < SLOTS && !took; i++) begin
              if (!busy[i]) begin
                busy[i]    = 1'b1;
                period[i]  = w.period_ms;
                trigger[i] = w.now_ms + {16'h0000, w.period_ms};
                reps[i]    = w.repeat_count;
                main_ev[i] = {w.has_action, w.action_id};
                alt_ev[i]  = {w.has_alternate, w.alternate_id};
                done_ev[i] = {w.has_callback, w.callback_id};
                live_count++;
                took = 1'b1;
                queue_reply(KIND_ADD_REPLY, 8'(i), 8'h00, 1'b1);
              end
            end
          end
          // refused add reports the occupancy in the slot field
          if (!took) queue_reply(KIND_ADD_REPLY, live_count, 8'h00, 1'b0);
        end
        ACT_CANCEL: begin
          freed = 1'b0;
          if (w.slot_index < SLOTS && busy[w.slot_index]) begin
            busy[w.slot_index] = 1'b0;
            live_count--;
            freed = 1'b1;
          end
          queue_reply(KIND_CANCEL_REPLY, w.slot_index, 8'h00, freed);
        end
        ACT_TICK: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (busy[i] && !(w.now_ms < trigger[i])) begin
              if (main_ev[i].vld) queue_reply(KIND_ACTION, 8'(i), main_ev[i].id, 1'b0);
              if (reps[i] == 16'd1) begin
                // finished: freed before the callback word is built
                busy[i] = 1'b0;
                live_count--;
                if (done_ev[i].vld) queue_reply(KIND_CALLBACK, 8'(i), done_ev[i].id, 1'b0);
              end else begin
                trigger[i] = w.now_ms + {16'h0000, period[i]};
                if (alt_ev[i].vld) begin
                  swap       = main_ev[i];
                  main_ev[i] = alt_ev[i];
                  alt_ev[i]  = swap;
                end
                if (reps[i] > 16'd1) reps[i]--;
              end
            end
          end
          queue_reply(KIND_TICK_DONE, 8'h00, 8'h00, 1'b0);
        end
        default: ;
      endcase
      if (awaited_q.size() > n0) begin
        t = awaited_q.pop_back();
        t.last = 1'b1;
        awaited_q.push_back(t);
      end
    endfunction

    function void field_check(string name, int unsigned exp_v, int unsigned got_v);
      if (exp_v != got_v) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, exp_v, got_v);
      end
    endfunction

    function void match_reply(tsts_out_t got);
      tsts_out_t e;
      if (awaited_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t unexpected result: expected none, actual %h", $time, got);
      end else begin
        e = awaited_q.pop_front();
        field_check("kind", e.kind, got.kind);
        field_check("slot", e.slot, got.slot);
        field_check("event_id", e.event_id, got.event_id);
        field_check("accepted", e.accepted, got.accepted);
        field_check("active_count", e.active_count, got.active_count);
        field_check("last", e.last, got.last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  tsts_in_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  tsts_out_t out_word;

  always #5 clk = ~clk;

  timer_slot_table_scheduler #(
    .SLOTS(SLOTS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  slot_table_scoreboard sb = new();

  int          send_idle_pct = 38;  // % of cycles the sender holds back
  int          recv_idle_pct = 46;  // % of cycles the receiver stalls
  bit          hold_go       = 1'b0;
  int          hold_left     = 0;
  int          quiet_cycles  = 0;
  logic [31:0] cur_now       = '0;

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go   = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: both channels sampled on the edge that accepts a word. Result
  // checked before the new input is applied; the FIFO keeps order anyway.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.match_reply(out_word);
      if (in_valid && !in_stall) sb.apply_command(in_word);
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Watchdog: nothing moving for too long means a hang
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  // Offer one word and return on the edge that takes it. valid is only
  // dropped when an idle gap is inserted, so back-to-back words keep it high.
  task automatic send(tsts_in_t w);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // every field random; callers then fix what matters
  function automatic tsts_in_t noise_word();
    tsts_in_t w;
    w.action        = 2'($urandom_range(0, 3));
    w.period_ms     = 16'($urandom);
    w.repeat_count  = 16'($urandom);
    w.has_action    = 1'($urandom);
    w.action_id     = 8'($urandom);
    w.has_alternate = 1'($urandom);
    w.alternate_id  = 8'($urandom);
    w.has_callback  = 1'($urandom);
    w.callback_id   = 8'($urandom);
    w.slot_index    = 8'($urandom);
    w.now_ms        = $urandom;
    return w;
  endfunction

  task automatic send_add(logic [31:0] now, logic [15:0] per, logic [15:0] count,
                          tsts_ev_t m, tsts_ev_t a, tsts_ev_t d);
    tsts_in_t w;
    w = noise_word();
    w.action        = ACT_ADD;
    w.now_ms        = now;
    w.period_ms     = per;
    w.repeat_count  = count;
    w.has_action    = m.vld;
    w.action_id     = m.id;
    w.has_alternate = a.vld;
    w.alternate_id  = a.id;
    w.has_callback  = d.vld;
    w.callback_id   = d.id;
    send(w);
  endtask

  task automatic send_cancel(logic [7:0] idx);
    tsts_in_t w;
    w = noise_word();
    w.action     = ACT_CANCEL;
    w.slot_index = idx;
    send(w);
  endtask

  task automatic send_tick(logic [31:0] now);
    tsts_in_t w;
    w = noise_word();
    w.action = ACT_TICK;
    w.now_ms = now;
    send(w);
  endtask

  // Random traffic: time mostly creeps forward with short periods so slots
  // keep firing, rearming and finishing; now and then a wide period, a huge
  // repeat count, a wild slot index or a jump in time.
  task automatic random_traffic(int n_items);
    tsts_in_t w;
    int       done_items;
    int       r;
    done_items = 0;
    while (done_items < n_items) begin
      w = noise_word();
      r = $urandom_range(0, 99);
      if (r < 35) begin
        w.action       = ACT_ADD;
        w.now_ms       = cur_now;
        w.period_ms    = ($urandom_range(0, 19) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 25));
        w.repeat_count = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 4));
        done_items++;
      end else if (r < 50) begin
        w.action = ACT_CANCEL;
        if ($urandom_range(0, 7) != 0) w.slot_index = 8'($urandom_range(0, SLOTS - 1));
        done_items++;
      end else if (r < 97) begin
        if ($urandom_range(0, 39) == 0)
          cur_now = $urandom;
        else
          cur_now = cur_now + 32'($urandom_range(0, 8));
        w.action = ACT_TICK;
        w.now_ms = cur_now;
        done_items++;
      end else begin
        w.action = ACT_UNUSED;   // dropped by the block, not counted
      end
      send(w);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed ----
    send_tick(32'h0000_0000);               // empty table: tick done only
    send_cancel(8'd0);                      // empty slot
    send_cancel(8'd8);                      // just out of range
    send_cancel(8'hFF);                     // far out of range
    // slot 0: one-shot, fires at once, callback on finish
    send_add(32'd100, 16'd0, 16'd1, {1'b1, 8'hA5}, {1'b0, 8'h11}, {1'b1, 8'h5A});
    // slot 1: no main action, alternate present, two firings
    send_add(32'd100, 16'd5, 16'd2, {1'b0, 8'h22}, {1'b1, 8'h3C}, {1'b0, 8'h33});
    // slot 2: widest period, one-shot
    send_add(32'd100, 16'hFFFF, 16'd1, {1'b1, 8'hFF}, {1'b1, 8'h00}, {1'b1, 8'hFF});
    send_tick(32'd100);                     // slot 0 fires and finishes
    send_tick(32'd105);                     // slot 1 silent firing, swaps in alternate
    send_tick(32'd110);                     // slot 1 fires alternate, freed silently
    // fill the table: slots 0, 1, 3..7 as one-shots with callbacks
    repeat (SLOTS - 1)
      send_add(32'd200, 16'd0, 16'd1, {1'b1, 8'($urandom)}, {1'($urandom), 8'($urandom)},
               {1'b1, 8'($urandom)});
    send_add(32'd200, 16'd1, 16'd0, {1'b1, 8'h01}, {1'b0, 8'h02}, {1'b0, 8'h03}); // full
    begin : drop_unused
      tsts_in_t w;
      w = noise_word();
      w.action = ACT_UNUSED;
      send(w);
    end
    send_tick(32'hFFFF_FFFF);               // every slot due: action + callback each
    send_cancel(8'd3);                      // now empty again
    // trigger wraps past 2^32; huge finite repeat count
    send_add(32'hFFFF_FFF0, 16'h0020, 16'hFFFF, {1'b1, 8'h0F}, {1'b1, 8'hF0},
             {1'b1, 8'h77});
    send_tick(32'h0000_0008);               // not yet due
    send_tick(32'h0000_0010);               // due after the wrap
    cur_now = 32'h0000_0010;

    // ---- random, sender lighter idling than the receiver ----
    random_traffic(PHASE_ITEMS);

    // ---- random, roles swapped; long output hold-off backs the block up ----
    send_idle_pct = 46;
    recv_idle_pct = 38;
    hold_go = 1'b1;
    random_traffic(PHASE_ITEMS);

    // ---- random, no idling either side ----
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_traffic(PHASE_ITEMS);

    in_valid <= 1'b0;

    // drain; the watchdog covers a result that never shows
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
